// ----- rtl/kpi_pkg.sv -----
// shared constants, types and helper functions of the k-mer position index
package kpi_pkg;

    localparam int MAX_K        = 3;
    localparam int BUCKET_SLOTS = 16;
    localparam int POS_BITS     = 16;
    localparam int ALPHABET     = 26;

    function automatic int pow_alpha(input int n);
        int p;
        p = 1;
        for (int i = 0; i < n; i++) begin
            p = p * ALPHABET;
        end
        return p;
    endfunction

    localparam int NUM_BUCKETS = pow_alpha(MAX_K);
    localparam int BKT_W       = $clog2(NUM_BUCKETS);
    localparam int FILL_W      = $clog2(BUCKET_SLOTS + 1);
    localparam int META_W      = FILL_W + 1;
    localparam int ST_DEPTH    = NUM_BUCKETS * BUCKET_SLOTS;
    localparam int ST_AW       = $clog2(ST_DEPTH);
    localparam int K_W         = $clog2(MAX_K + 1);
    localparam int CMD_W       = 3;
    localparam int SYM_W       = 5;
    localparam int LEN_W       = 2;
    localparam int END_W       = POS_BITS + 1;
    localparam int ID_W        = ((CMD_W + SYM_W + 7) / 8) * 8;
    localparam int OD_W        = ((POS_BITS + END_W + 7) / 8) * 8;
    localparam int CFG_IDX_W   = 1;

    localparam logic [CMD_W-1:0] CMD_SEQ     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_TAG     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_LOOKUP  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_FLATTEN = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_KMER_LENGTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIFF_KQ     = 1'd1;

    localparam logic [SYM_W-1:0] LTR_I = 5'd8;
    localparam logic [SYM_W-1:0] LTR_K = 5'd10;
    localparam logic [SYM_W-1:0] LTR_L = 5'd11;
    localparam logic [SYM_W-1:0] LTR_Q = 5'd16;
    localparam logic [SYM_W-1:0] LTR_Z = 5'd25;

    typedef struct packed {
        logic [BKT_W-1:0]    bucket;
        logic [POS_BITS-1:0] start;
        logic                act;
        logic [CMD_W-1:0]    cmd;
    } t_front;

    function automatic logic [K_W-1:0] eff_k(input logic [LEN_W-1:0] len);
        if (len == '0) begin
            return K_W'(1);
        end
        if (int'(len) > MAX_K) begin
            return K_W'(MAX_K);
        end
        return K_W'(len);
    endfunction

endpackage

// ----- rtl/kpi_ram.sv -----
// generic simple dual-port ram with registered read
module kpi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/kpi_front.sv -----
// letter folding, rolling letter window, stream position and bucket code
module kpi_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_take,
    input  logic [kpi_pkg::CMD_W-1:0]  i_cmd,
    input  logic [kpi_pkg::SYM_W-1:0]  i_sym,
    input  logic                       i_first,
    input  logic [kpi_pkg::K_W-1:0]    i_k,
    input  logic                       i_diff,
    output kpi_pkg::t_front            o_front
);
    import kpi_pkg::*;

    logic [SYM_W-1:0]    r_ltr [MAX_K];
    logic [SYM_W-1:0]    n_ltr [MAX_K];
    logic [K_W-1:0]      r_seen, n_seen, seen_base;
    logic [POS_BITS-1:0] r_pos, n_pos, pos_base;
    logic [SYM_W-1:0]    sym, folded;
    logic [BKT_W-1:0]    acc;
    logic                is_seq;

    always_comb begin
        is_seq = (i_cmd == CMD_SEQ);
        sym    = (i_sym > LTR_Z) ? LTR_Z : i_sym;
        folded = sym;
        if (sym == LTR_L) begin
            folded = LTR_I;
        end else if (sym == LTR_Q && !i_diff) begin
            folded = LTR_K;
        end
        n_ltr[0] = folded;
        for (int j = 1; j < MAX_K; j++) begin
            n_ltr[j] = i_first ? '0 : r_ltr[j-1];
        end
        seen_base = i_first ? '0 : r_seen;
        n_seen    = (int'(seen_base) < MAX_K) ? seen_base + K_W'(1) : seen_base;
        pos_base  = (i_first && is_seq) ? '0 : r_pos;
        n_pos     = is_seq ? pos_base + POS_BITS'(1) : r_pos;
        acc = '0;
        for (int j = 0; j < MAX_K; j++) begin
            if (j < int'(i_k)) begin
                acc = acc + BKT_W'(pow_alpha(j)) * BKT_W'(n_ltr[j]);
            end
        end
        o_front.bucket = acc;
        o_front.start  = pos_base - POS_BITS'(i_k) + POS_BITS'(1);
        o_front.cmd    = i_cmd;
        if (is_seq) begin
            o_front.act = (n_seen >= i_k);
        end else begin
            o_front.act = (seen_base < i_k) && (n_seen == i_k);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < MAX_K; j++) begin
                r_ltr[j] <= '0;
            end
            r_seen <= '0;
            r_pos  <= '0;
        end else if (i_take) begin
            r_ltr  <= n_ltr;
            r_seen <= n_seen;
            r_pos  <= n_pos;
        end
    end
endmodule

// ----- rtl/kmer_position_index.sv -----
// top level of the k-mer position index: bucket control and result output
//
// channel  dir  handshake                       payload
// s        in   i_s_tvalid / o_s_tready         tdata {symbol, command}, tuser first
// m        out  o_m_tvalid / i_m_tready         tdata {end, start}, tuser {overflow, hit}
// cfg      in   i_cfg_valid / o_cfg_ready       i_cfg_index, i_cfg_data
//
// sequence and tag letters: accept with bucket read, then write back
// answering lookups read each stored position (S_LREAD) and emit it (S_LCAP), a miss emits one word (S_EMIT)
// flatten and clear sweep the bucket memory, then emit one done word
// after reset a clearing pass over all NUM_BUCKETS buckets runs before the first word is taken
// a stalled output holds the sequencer; config writes are taken at any time
module kmer_position_index (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [kpi_pkg::ID_W-1:0]        i_s_tdata,   // command, symbol
    input  logic                            i_s_tuser,   // first
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [kpi_pkg::OD_W-1:0]        o_m_tdata,   // start_position, end_position
    output logic [1:0]                      o_m_tuser,   // hit, overflow
    output logic                            o_m_tlast,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [kpi_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [kpi_pkg::LEN_W-1:0]       i_cfg_data
);
    import kpi_pkg::*;

    typedef enum logic [2:0] {
        S_INIT, S_IDLE, S_MOD, S_LREAD, S_LCAP, S_EMIT, S_SWEEP, S_DRAIN
    } t_state;

    t_state              r_state;
    logic [LEN_W-1:0]    r_klen;
    logic                r_diff;
    logic [K_W-1:0]      k;
    t_front              front;
    logic [BKT_W-1:0]    r_bucket, r_cnt, r_wa;
    logic [POS_BITS-1:0] r_start;
    logic [CMD_W-1:0]    r_cmd;
    logic                r_act, r_wv, r_clr, r_ovf, r_ovf_done, r_eovf;
    logic [FILL_W-1:0]   r_n, r_i;
    logic                r_ovalid, r_ohit, r_olast, r_oovf;
    logic [POS_BITS-1:0] r_ostart;
    logic [END_W-1:0]    r_oend;
    logic                take, take_letter, out_free;
    logic [CMD_W-1:0]    in_cmd;
    logic                meta_we, meta_re, st_we, st_re;
    logic [BKT_W-1:0]    meta_wa, meta_ra;
    logic [META_W-1:0]   meta_wd, meta_rd;
    logic [ST_AW-1:0]    st_wa, st_ra, bkt_base;
    logic [POS_BITS-1:0] st_rd;
    logic                rd_mark;
    logic [FILL_W-1:0]   rd_fill;

    assign k           = eff_k(r_klen);
    assign in_cmd      = i_s_tdata[CMD_W-1:0];
    assign o_s_tready  = (r_state == S_IDLE);
    assign take        = i_s_tvalid && o_s_tready;
    assign take_letter = take && (in_cmd == CMD_SEQ || in_cmd == CMD_TAG || in_cmd == CMD_LOOKUP);
    assign out_free    = !r_ovalid || i_m_tready;
    assign o_cfg_ready = 1'b1;
    assign rd_mark     = meta_rd[FILL_W];
    assign rd_fill     = meta_rd[FILL_W-1:0];
    assign bkt_base    = ST_AW'(r_bucket) * ST_AW'(BUCKET_SLOTS);

    kpi_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take_letter),
        .i_cmd   (in_cmd),
        .i_sym   (i_s_tdata[CMD_W+SYM_W-1:CMD_W]),
        .i_first (i_s_tuser),
        .i_k     (k),
        .i_diff  (r_diff),
        .o_front (front)
    );

    kpi_ram #(.WIDTH(META_W), .DEPTH(NUM_BUCKETS)) u_meta (
        .i_clk   (i_clk),
        .i_we    (meta_we),
        .i_waddr (meta_wa),
        .i_wdata (meta_wd),
        .i_re    (meta_re),
        .i_raddr (meta_ra),
        .o_rdata (meta_rd)
    );

    kpi_ram #(.WIDTH(POS_BITS), .DEPTH(ST_DEPTH)) u_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_wa),
        .i_wdata (r_start),
        .i_re    (st_re),
        .i_raddr (st_ra),
        .o_rdata (st_rd)
    );

    always_comb begin
        meta_re = take_letter || (r_state == S_SWEEP);
        meta_ra = (r_state == S_SWEEP) ? r_cnt : front.bucket;
        meta_we = 1'b0;
        meta_wa = r_bucket;
        meta_wd = '0;
        st_we   = 1'b0;
        st_wa   = bkt_base + ST_AW'(rd_fill);
        st_re   = (r_state == S_LREAD);
        st_ra   = bkt_base + ST_AW'(r_i);
        case (r_state)
            S_INIT: begin
                meta_we = 1'b1;
                meta_wa = r_cnt;
            end
            S_SWEEP, S_DRAIN: begin
                meta_we = r_wv;
                meta_wa = r_wa;
                meta_wd = {(!r_clr && rd_mark), {FILL_W{1'b0}}};
            end
            S_MOD: begin
                if (r_act && r_cmd == CMD_SEQ && rd_mark && int'(rd_fill) < BUCKET_SLOTS) begin
                    st_we   = 1'b1;
                    meta_we = 1'b1;
                    meta_wd = {1'b1, rd_fill + FILL_W'(1)};
                end else if (r_act && r_cmd == CMD_TAG) begin
                    meta_we = 1'b1;
                    meta_wd = {1'b1, rd_fill};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_INIT;
            r_klen     <= LEN_W'(3);
            r_diff     <= 1'b0;
            r_cnt      <= '0;
            r_wv       <= 1'b0;
            r_clr      <= 1'b1;
            r_ovf      <= 1'b0;
            r_ovf_done <= 1'b0;
            r_eovf     <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == REG_KMER_LENGTH) begin
                    r_klen <= i_cfg_data;
                end else if (i_cfg_index == REG_DIFF_KQ) begin
                    r_diff <= i_cfg_data[0];
                end
            end
            if (r_ovalid && i_m_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_INIT: begin
                    r_cnt <= r_cnt + BKT_W'(1);
                    if (r_cnt == BKT_W'(NUM_BUCKETS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (take_letter) begin
                        r_bucket <= front.bucket;
                        r_start  <= front.start;
                        r_act    <= front.act;
                        r_cmd    <= front.cmd;
                        r_state  <= S_MOD;
                    end else if (take && (in_cmd == CMD_FLATTEN || in_cmd == CMD_CLEAR)) begin
                        r_ovf_done <= r_ovf;
                        r_ovf      <= 1'b0;
                        r_clr      <= (in_cmd == CMD_CLEAR);
                        r_cnt      <= '0;
                        r_wv       <= 1'b0;
                        r_state    <= S_SWEEP;
                    end
                end
                S_MOD: begin
                    r_state <= S_IDLE;
                    if (r_act && r_cmd == CMD_SEQ && rd_mark
                        && int'(rd_fill) >= BUCKET_SLOTS) begin
                        r_ovf <= 1'b1;
                    end
                    if (r_act && r_cmd == CMD_LOOKUP) begin
                        r_i <= '0;
                        if (!rd_mark || rd_fill == '0) begin
                            r_eovf  <= r_ovf;
                            r_state <= S_EMIT;
                        end else begin
                            r_n     <= rd_fill;
                            r_state <= S_LREAD;
                        end
                    end
                end
                S_LREAD: begin
                    r_state <= S_LCAP;
                end
                S_LCAP: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_ostart <= st_rd;
                        r_oend   <= END_W'(st_rd) + END_W'(k) - END_W'(1);
                        r_ohit   <= 1'b1;
                        r_olast  <= (r_i + FILL_W'(1) == r_n);
                        r_oovf   <= r_ovf;
                        r_i      <= r_i + FILL_W'(1);
                        r_state  <= (r_i + FILL_W'(1) == r_n) ? S_IDLE : S_LREAD;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_ostart <= '0;
                        r_oend   <= '0;
                        r_ohit   <= 1'b0;
                        r_olast  <= 1'b1;
                        r_oovf   <= r_eovf;
                        r_state  <= S_IDLE;
                    end
                end
                S_SWEEP: begin
                    r_wa  <= r_cnt;
                    r_wv  <= 1'b1;
                    r_cnt <= r_cnt + BKT_W'(1);
                    if (r_cnt == BKT_W'(NUM_BUCKETS - 1)) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_wv    <= 1'b0;
                    r_eovf  <= r_ovf_done;
                    r_state <= S_EMIT;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {{(OD_W - POS_BITS - END_W){1'b0}}, r_oend, r_ostart};
    assign o_m_tuser  = {r_oovf, r_ohit};
    assign o_m_tlast  = r_olast;

    a_lcap_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_LCAP |-> r_i < r_n)
        else $error("lookup slot index beyond bucket fill");

    a_letter_to_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take_letter |=> r_state == S_MOD)
        else $error("accepted letter did not reach write back");

    a_store_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        st_we |-> (rd_mark && int'(rd_fill) < BUCKET_SLOTS))
        else $error("store write into full or unmarked bucket");

    a_no_take_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP || r_state == S_INIT) |-> !o_s_tready)
        else $error("input word taken during sweep");
endmodule
